// ----- hdl/pcxrle_pkg.sv -----
// Shared constants, codes and the job record of the PCX planar decoder.
package pcxrle_pkg;

  localparam int PLANE_COLUMNS = 80;
  localparam int PLANE_COUNT   = 4;
  localparam int LINE_PIXELS   = PLANE_COLUMNS * PLANE_COUNT;

  localparam int POS_W  = 9;
  localparam int ROW_W  = 10;
  localparam int RUN_W  = 6;
  localparam int WIDE_W = 11;
  localparam int PCOL_W = 9;
  localparam int ADDR_W = 16;
  localparam int CFG_W  = 10;

  localparam logic [WIDE_W-1:0] POS_MAX     = 11'd511;
  localparam logic [WIDE_W-1:0] LINE_PIX_W  = WIDE_W'(LINE_PIXELS);
  localparam logic [PCOL_W-1:0] PCOL_CONST  = PCOL_W'(PLANE_COLUMNS);
  localparam logic [1:0]        RUN_MARK    = 2'b11;

  localparam logic [POS_W-1:0] BPL_RESET   = 9'd320;
  localparam logic [ROW_W-1:0] LINES_RESET = 10'd200;

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [7:0]       pixel;
    logic [POS_W-1:0] pos;
    logic [ROW_W-1:0] row;
    logic [RUN_W-1:0] count;
    logic             ends_line;
    logic             ends_image;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_ctl_t;

endpackage

// ----- hdl/pcxrle_front.sv -----
// Front part: takes coded bytes, tracks run, line and image state, queues pixel jobs.
module pcxrle_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                   q_full,
  output logic                   q_push,
  output pcxrle_pkg::job_t       q_job
);
  import pcxrle_pkg::*;

  logic [POS_W-1:0] bpl_r;
  logic [ROW_W-1:0] lines_r;
  logic             await_r, await_nxt, await_eff;
  logic [RUN_W-1:0] run_r, run_nxt, run_eff;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [ROW_W-1:0] row_r, row_nxt, row_eff;
  logic             done_r, done_nxt, done_eff;
  logic [RUN_W-1:0] count;
  logic [WIDE_W-1:0] sum, lim;
  logic [POS_W-1:0] newpos;
  logic             ends_line, ends_image, accept;
  logic [RUN_W-1:0] emit;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    await_eff = in_tuser ? 1'b0 : await_r;
    run_eff   = in_tuser ? '0 : run_r;
    pos_eff   = in_tuser ? '0 : pos_r;
    row_eff   = in_tuser ? '0 : row_r;
    done_eff  = in_tuser ? 1'b0 : done_r;
    await_nxt = await_eff;
    run_nxt   = run_eff;
    pos_nxt   = pos_eff;
    row_nxt   = row_eff;
    done_nxt  = done_eff;
    count     = '0;
    if (!done_eff) begin
      if (await_eff) begin
        await_nxt = 1'b0;
        count     = run_eff;
      end else if (in_tdata[7:6] == RUN_MARK) begin
        run_nxt   = in_tdata[5:0];
        await_nxt = 1'b1;
      end else begin
        count = RUN_W'(1);
      end
    end
    sum        = {2'b00, pos_eff} + {{(WIDE_W-RUN_W){1'b0}}, count};
    newpos     = (sum > POS_MAX) ? POS_MAX[POS_W-1:0] : sum[POS_W-1:0];
    ends_line  = (count != '0) && (newpos >= bpl_r);
    ends_image = ends_line && (({1'b0, row_eff} + 11'd1) >= {1'b0, lines_r});
    // Pixels past the line store are dropped; the emitted ones form a prefix of the run.
    lim  = (sum > LINE_PIX_W) ? LINE_PIX_W : sum;
    emit = ({2'b00, pos_eff} < LINE_PIX_W) ? RUN_W'(lim - {2'b00, pos_eff}) : '0;
    if (count != '0) begin
      if (ends_line) begin
        pos_nxt = '0;
        if (ends_image) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_eff + ROW_W'(1);
        end
      end else begin
        pos_nxt = newpos;
      end
    end
  end

  assign q_push           = accept && (emit != '0);
  assign q_job.pixel      = in_tdata;
  assign q_job.pos        = pos_eff;
  assign q_job.row        = row_eff;
  assign q_job.count      = emit;
  assign q_job.ends_line  = ends_line;
  assign q_job.ends_image = ends_image;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r   <= BPL_RESET;
      lines_r <= LINES_RESET;
      await_r <= 1'b0;
      run_r   <= '0;
      pos_r   <= '0;
      row_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH: bpl_r   <= cfg_wdata[POS_W-1:0];
          REG_LINE_COUNT: lines_r <= cfg_wdata[ROW_W-1:0];
          default:        bpl_r   <= bpl_r;
        endcase
      end
      if (accept) begin
        await_r <= await_nxt;
        run_r   <= run_nxt;
        pos_r   <= pos_nxt;
        row_r   <= row_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // A pending run value is always handled before the image can complete.
  a_await_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(await_r && done_r)) else $error("run pending after image end");

endmodule

// ----- hdl/pcxrle_queue.sv -----
// Short job queue between the front and back parts.
module pcxrle_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pcxrle_pkg::job_t       push_job,
  input  logic                   pop,
  output pcxrle_pkg::job_t       head_job,
  output pcxrle_pkg::queue_ctl_t ctl
);
  import pcxrle_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign ctl.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign ctl.valid = (cnt_r != '0);
  assign do_push   = push && !ctl.full;
  assign do_pop    = pop && ctl.valid;
  assign head_job  = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_job;
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

// ----- hdl/pcxrle_back.sv -----
// Back part: jobs become one pixel write per cycle unless stalled, via an output register.
module pcxrle_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcxrle_pkg::queue_ctl_t qctl,
  input  pcxrle_pkg::job_t       head_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,
  output logic                   out_tlast,
  output logic [1:0]             out_tuser
);
  import pcxrle_pkg::*;

  localparam int PROD_W = ROW_W + PCOL_W;

  logic              active_r;
  logic [7:0]        pixel_r;
  logic [WIDE_W-1:0] n_r;
  logic [RUN_W-1:0]  left_r;
  logic [ADDR_W-1:0] base_r;
  logic              eline_r, eimage_r;
  logic              fire, final_pix;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr;

  logic              ov_r;
  logic [1:0]        o_plane_r;
  logic [ADDR_W-1:0] o_addr_r;
  logic [7:0]        o_pixel_r;
  logic              o_last_r, o_line_r, o_image_r;

  assign fire      = active_r && (!ov_r || out_tready);
  assign final_pix = (left_r == RUN_W'(1));
  assign q_pop     = qctl.valid && (!active_r || (fire && final_pix));
  assign prod      = {{PCOL_W{1'b0}}, head_job.row} * {{ROW_W{1'b0}}, PCOL_CONST};
  assign addr      = base_r + ADDR_W'(n_r >> 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (fire && final_pix) begin
        active_r <= 1'b0;
      end
      if (fire) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_r  <= head_job.pixel;
      n_r      <= {2'b00, head_job.pos};
      left_r   <= head_job.count;
      base_r   <= prod[ADDR_W-1:0];
      eline_r  <= head_job.ends_line;
      eimage_r <= head_job.ends_image;
    end else if (fire) begin
      n_r    <= n_r + WIDE_W'(1);
      left_r <= left_r - RUN_W'(1);
    end
    if (fire) begin
      o_plane_r <= n_r[1:0];
      o_addr_r  <= addr;
      o_pixel_r <= pixel_r;
      o_last_r  <= final_pix;
      o_line_r  <= final_pix && eline_r;
      o_image_r <= final_pix && eimage_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_pixel_r, o_addr_r, o_plane_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = {o_image_r, o_line_r};

  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r != '0)) else $error("active job with no pixels left");

  a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (o_line_r || o_image_r)) |-> (o_last_r && (o_line_r || !o_image_r)))
    else $error("line or image end off the final pixel");

endmodule

// ----- hdl/pcx_rle_planar_decoder.sv -----
// Top level of the PCX run-length decoder for a four-plane frame buffer.
//
// The input channel takes one coded byte per item; in_tuser set on an item
// clears row, position and any pending run before that byte is decoded.
// The result channel gives one pixel write per item: plane, address within
// the plane and pixel byte. out_tlast marks the final pixel caused by an
// input byte; out_tuser flags the end of a scan line and of the image there.
// Run header bytes and bytes after the image end give no result.
// A literal byte's pixel passes the job queue, the back part's job registers
// and the output register before out_tvalid rises for it.
// A run gives one pixel per cycle while the receiver is ready, and holds the
// back part until its stored pixels are written; the front keeps taking bytes
// until the four-entry job queue is full. Input is paced by the back part
// writing one pixel a cycle whenever the receiver takes it.
// When the receiver stalls, the output register holds its item, the back
// part waits, and the queue fills before in_tready falls.
// Reset (synchronous, active low) empties the queue, clears decode state and
// loads the line width with 320 and the line count with 200.
// Configuration writes take effect at the edge where cfg_we is high.
module pcx_rle_planar_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] code_byte
  input  logic        in_tuser,    // [0] start_image
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [1:0] plane, [17:2] plane_address, [25:18] pixel_value
  output logic        out_tlast,
  output logic [1:0]  out_tuser    // [0] line_end, [1] image_end
);
  import pcxrle_pkg::*;

  job_t       push_job, head_job;
  logic       q_push, q_pop;
  queue_ctl_t qctl;

  // The front part owns all decode state and the configuration registers.
  pcxrle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (qctl.full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Each queued job is one byte's worth of stored pixels.
  pcxrle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .ctl      (qctl)
  );

  // The back part turns a job into consecutive plane writes.
  pcxrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qctl       (qctl),
    .head_job   (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- verif/pcx_pixel_checker.sv -----
// Checker for the PCX planar decoder: predicts pixel writes and compares them.
module pcx_pixel_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tuser,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [31:0]                 out_tdata,
  input  logic                        out_tlast,
  input  logic [1:0]                  out_tuser,
  output int                          fail_count,
  output int                          pending_results
);
  import pcxrle_pkg::*;

  typedef struct packed {
    logic [1:0]        plane;
    logic [ADDR_W-1:0] address;
    logic [7:0]        pixel;
    logic              last;
    logic              line_end;
    logic              image_end;
  } pixel_write_t;

  pixel_write_t pixel_writes_due[$];

  logic [POS_W-1:0] line_width_q;
  logic [ROW_W-1:0] line_count_q;
  logic             awaiting_value;
  logic [RUN_W-1:0] run_length;
  logic [POS_W-1:0] line_pos;
  logic [ROW_W-1:0] row;
  logic             image_done;

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  // Decodes one accepted byte and queues the pixel writes it causes.
  task automatic decode_code_byte(input logic [7:0] code, input logic start);
    int unsigned  count;
    int unsigned  next_pos;
    int unsigned  n;
    int unsigned  col;
    logic         ends_line;
    logic         ends_image;
    logic         have_held;
    pixel_write_t held;
    have_held = 1'b0;
    held = '0;
    if (start) begin
      awaiting_value = 1'b0;
      run_length = '0;
      line_pos = '0;
      row = '0;
      image_done = 1'b0;
    end
    if (image_done) return;
    if (awaiting_value) begin
      awaiting_value = 1'b0;
      count = run_length;
    end else if (code[7:6] == RUN_MARK) begin
      run_length = code[RUN_W-1:0];
      awaiting_value = 1'b1;
      return;
    end else begin
      count = 1;
    end
    if (count == 0) return;

    next_pos = line_pos + count;
    if (next_pos > POS_MAX) next_pos = POS_MAX;
    ends_line = (next_pos >= line_width_q);
    ends_image = ends_line && (int'(row) + 1 >= int'(line_count_q));

    // Pixels past the line store are dropped but still move the position.
    for (int unsigned k = 0; k < count; k++) begin
      n = line_pos + k;
      col = n / PLANE_COUNT;
      if (col >= PLANE_COLUMNS) continue;
      if (have_held) pixel_writes_due.push_back(held);
      held = '0;
      held.plane = 2'(n % PLANE_COUNT);
      held.address = ADDR_W'(int'(row) * PLANE_COLUMNS + col);
      held.pixel = code;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      held.line_end = ends_line;
      held.image_end = ends_image;
      pixel_writes_due.push_back(held);
    end

    if (ends_line) begin
      line_pos = '0;
      if (ends_image) image_done = 1'b1;
      else row = row + 1'b1;
    end else begin
      line_pos = POS_W'(next_pos);
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t got;
    pixel_write_t want;
    if (!rst_n) begin
      line_width_q = BPL_RESET;
      line_count_q = LINES_RESET;
      awaiting_value = 1'b0;
      run_length = '0;
      line_pos = '0;
      row = '0;
      image_done = 1'b0;
      pixel_writes_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LINE_WIDTH) line_width_q = cfg_wdata[POS_W-1:0];
        else if (cfg_index == REG_LINE_COUNT) line_count_q = cfg_wdata[ROW_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[17:2], out_tdata[25:18],
               out_tlast, out_tuser[0], out_tuser[1]};
        if (pixel_writes_due.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected pixel write p%0d a%0h v%0h f%b%b%b",
                     got.plane, got.address, got.pixel, got.last, got.line_end, got.image_end);
          fail_count++;
        end else begin
          want = pixel_writes_due.pop_front();
          if (got.plane !== want.plane || got.address !== want.address ||
              got.pixel !== want.pixel || got.last !== want.last ||
              got.line_end !== want.line_end || got.image_end !== want.image_end) begin
            if (fail_count < 10)
              $display("ERROR: want p%0d a%0h v%0h f%b%b%b, got p%0d a%0h v%0h f%b%b%b",
                       want.plane, want.address, want.pixel,
                       want.last, want.line_end, want.image_end,
                       got.plane, got.address, got.pixel,
                       got.last, got.line_end, got.image_end);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_code_byte(in_tdata, in_tuser);
    end
    pending_results = pixel_writes_due.size();
  end

endmodule

// ----- verif/tb_pcx_rle_planar_decoder.sv -----
// Testbench top for the PCX planar decoder: stimulus, receiver stalls and verdict.
module tb_pcx_rle_planar_decoder;
  import pcxrle_pkg::*;

  // A quiet stretch longer than this means the block has hung. The longest
  // legal quiet stretch is the receiver hold-off below, plus a short drain.
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  // Quiet cycles left after the last expected pixel before a register write.
  localparam int DRAIN_CYCLES = 16;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_LINE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;
  logic             out_tlast;
  logic [1:0]       out_tuser;

  int   fail_count;
  int   pending_results;
  logic hold_request = 1'b0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pcx_rle_planar_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  pcx_pixel_checker pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Receiver: the stall rate is drawn anew for each random span, from never
  // stalling to stalling most of the time. On request it holds off for a
  // long stretch so that the job queue fills and the input side stalls.
  initial begin : receiver
    int stall_pct;
    int span;
    stall_pct = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(20, 120);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        span--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [7:0] run_header(input int len);
    return {RUN_MARK, 6'(len)};
  endfunction

  // Offers one byte and returns at the edge where it is taken. The sender
  // works in bursts; at the start of a burst it usually idles for a while,
  // and some bursts follow the previous one with no gap at all.
  task automatic send_byte(input logic [7:0] code, input logic start);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= code;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stops offering bytes and waits until every predicted pixel has come out,
  // then lets the block settle. Reads happen at the falling edge, where the
  // checker's count is stable.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] line_bytes, input logic [CFG_W-1:0] lines);
    wait_idle();
    write_reg(REG_LINE_WIDTH, line_bytes);
    write_reg(REG_LINE_COUNT, lines);
  endtask

  // Random coded stream. Most of it is well-formed: literals and run pairs
  // with random values. The rest is zero-length runs, runs cut short by a
  // start of image, and raw bytes of any value. A start of image is set on
  // a given share of the bytes so that finished images restart.
  task automatic send_random(input int units, input int start_pct, input int min_run,
                             input int max_run, input int literal_pct);
    int   pick;
    int   len;
    logic start;
    repeat (units) begin
      pick = $urandom_range(0, 99);
      start = ($urandom_range(0, 99) < start_pct);
      len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(min_run, max_run);
      if (pick < literal_pct) begin
        send_byte(8'($urandom_range(0, 191)), start);
      end else if (pick < 92) begin
        send_byte(run_header(len), start);
        send_byte(8'($urandom), 1'b0);
      end else if (pick < 96) begin
        // Run header whose value byte starts a new image instead.
        send_byte(run_header(len), start);
        send_byte(8'($urandom), 1'b1);
      end else begin
        send_byte(8'($urandom), start);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset geometry: literal extremes, a zero-length
    // run, the longest run with a value that carries the run marker, and a
    // start of image that lands on a pending run value or on a header.
    configure(CFG_W'(BPL_RESET), CFG_W'(LINES_RESET));
    send_byte(8'h00, 1'b1);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(run_header(0), 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(run_header(63), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(run_header(3), 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(run_header(2), 1'b0);
    send_byte(run_header(4), 1'b1);
    send_byte(8'h22, 1'b0);

    // A tiny image of two five-byte lines: an exact line end, then a run that
    // overshoots and ends the image, bytes ignored after it, and a restart.
    configure(CFG_W'(5), CFG_W'(2));
    send_byte(8'h01, 1'b1);
    send_byte(run_header(3), 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(run_header(10), 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(run_header(2), 1'b0);
    send_byte(8'h06, 1'b1);

    // Random part, one register setting per phase.
    configure(CFG_W'(BPL_RESET), CFG_W'(LINES_RESET));
    send_random(40, 3, 1, 63, 55);

    // One-byte lines and the largest line count: every pixel byte ends a
    // line, so the row climbs steadily.
    configure(CFG_W'(1), CFG_W'(1023));
    send_byte(8'h00, 1'b1);
    send_random(40, 0, 1, 3, 90);

    // Full write data: the line is wider than the line store, so long runs
    // are partly or wholly dropped and the position saturates at the end.
    configure('1, CFG_W'(1));
    send_random(25, 20, 32, 63, 20);

    configure(CFG_W'(7), CFG_W'(3));
    send_random(40, 15, 1, 12, 55);

    // Zero line width and zero line count: every pixel byte ends the image.
    configure(CFG_W'(0), CFG_W'(0));
    send_random(15, 30, 1, 63, 50);

    // The receiver holds off while bytes keep coming, so the queue fills.
    configure(CFG_W'(100), CFG_W'(5));
    hold_request = 1'b1;
    send_random(40, 10, 1, 40, 55);

    configure(CFG_W'(BPL_RESET), CFG_W'(1023));
    send_random(20, 2, 1, 63, 55);

    wait_idle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- pcx_rle_planar_decoder.f -----
hdl/pcxrle_pkg.sv
hdl/pcxrle_front.sv
hdl/pcxrle_queue.sv
hdl/pcxrle_back.sv
hdl/pcx_rle_planar_decoder.sv
verif/pcx_pixel_checker.sv
verif/tb_pcx_rle_planar_decoder.sv
